/* sv/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int unsigned FieldWidth = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned TdataWidth = 56;

  localparam logic [FieldWidth-1:0] MaxLengthReset = 16'd2048;

  // Result kind codes, carried on tuser.
  typedef enum logic [KindWidth-1:0] {
    KIND_BODY    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ID_ERR  = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FieldWidth-1:0] msg_id;
    logic [FieldWidth-1:0] msg_length;
    logic [ByteWidth-1:0]  data_byte;
    logic [FieldWidth-1:0] byte_index;
    logic                  last_byte;
  } result_t;

endpackage

/* sv/lpfd_parser.sv */
// ----------------------------------------------------------------------------
// lpfd_parser
// Header collection, limit checks and body byte counting, one byte per cycle while in_accept is high.
// ----------------------------------------------------------------------------
module lpfd_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_accept,
  input  logic [lpfd_pkg::ByteWidth-1:0]   in_byte,
  input  logic [lpfd_pkg::FieldWidth-1:0]  length_limit,
  output logic                             res_valid,
  output lpfd_pkg::result_t                res
);

  typedef enum logic [2:0] {
    ST_HEADER = 3'b001,
    ST_BODY   = 3'b010,
    ST_FAILED = 3'b100
  } state_t;

  state_t                          state, state_next;
  logic [1:0]                      header_count, header_count_next;
  logic [lpfd_pkg::FieldWidth-1:0] id_reg, id_reg_next;
  logic [lpfd_pkg::FieldWidth-1:0] len_reg, len_reg_next;
  logic [lpfd_pkg::FieldWidth-1:0] body_count, body_count_next;
  logic [lpfd_pkg::FieldWidth:0]   body_count_inc;
  logic                            body_last;

  assign body_count_inc = {1'b0, body_count} + 17'd1;
  assign body_last      = body_count_inc >= {1'b0, len_reg};

  always_comb begin
    state_next        = state;
    header_count_next = header_count;
    id_reg_next       = id_reg;
    len_reg_next      = len_reg;
    body_count_next   = body_count;
    res_valid         = 1'b0;
    res.kind          = lpfd_pkg::KIND_BODY;
    res.msg_id        = id_reg;
    res.msg_length    = len_reg;
    res.data_byte     = '0;
    res.byte_index    = '0;
    res.last_byte     = 1'b1;

    case (state)
      ST_HEADER: begin
        case (header_count)
          2'd0:    id_reg_next  = {in_byte, id_reg[7:0]};
          2'd1:    id_reg_next  = {id_reg[15:8], in_byte};
          2'd2:    len_reg_next = {in_byte, len_reg[7:0]};
          default: len_reg_next = {len_reg[15:8], in_byte};
        endcase
        res.msg_id     = id_reg_next;
        res.msg_length = len_reg_next;
        if (header_count != 2'd3) begin
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          if (id_reg_next > length_limit) begin
            res_valid  = 1'b1;
            res.kind   = lpfd_pkg::KIND_ID_ERR;
            state_next = ST_FAILED;
          end else if (len_reg_next > length_limit) begin
            res_valid  = 1'b1;
            res.kind   = lpfd_pkg::KIND_LEN_ERR;
            state_next = ST_FAILED;
          end else if (len_reg_next == '0) begin
            res_valid = 1'b1;
            res.kind  = lpfd_pkg::KIND_EMPTY;
          end else begin
            state_next      = ST_BODY;
            body_count_next = '0;
          end
        end
      end
      ST_BODY: begin
        res_valid      = 1'b1;
        res.kind       = lpfd_pkg::KIND_BODY;
        res.data_byte  = in_byte;
        res.byte_index = body_count;
        res.last_byte  = body_last;
        if (body_last) begin
          state_next      = ST_HEADER;
          body_count_next = '0;
        end else begin
          body_count_next = body_count_inc[lpfd_pkg::FieldWidth-1:0];
        end
      end
      default: begin
        // Session closed: bytes are consumed and dropped.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_HEADER;
      header_count <= 2'd0;
      id_reg       <= '0;
      len_reg      <= '0;
      body_count   <= '0;
    end else if (in_accept) begin
      state        <= state_next;
      header_count <= header_count_next;
      id_reg       <= id_reg_next;
      len_reg      <= len_reg_next;
      body_count   <= body_count_next;
    end
  end

endmodule

/* sv/lpfd_out_stage.sv */
// ----------------------------------------------------------------------------
// lpfd_out_stage
// Output register with one skid entry, so input acceptance never waits on
// the downstream ready in the same cycle.
// ----------------------------------------------------------------------------
module lpfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpfd_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfd_pkg::result_t out_data
);

  logic              skid_valid;
  lpfd_pkg::result_t skid_data;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_valid <= 1'b1;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

/* sv/length_prefixed_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core
// Splits a byte stream into messages with a 4-byte id/length header.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the s_ stream channel, one byte per request. Each
// message begins with a big-endian 16-bit message id and a big-endian 16-bit
// body length. Header bytes produce no output. After the fourth header byte
// the id and then the length are checked against the length limit register
// (written through cfg_wr_en/cfg_wr_data, reset value 2048). A value above
// the limit produces one error request and the block then drops every later
// byte until reset. A zero-length message produces one empty-message request.
// Every body byte produces one request on the m_ channel carrying the id,
// length, byte and its index; tlast marks the final request of a message and
// tuser carries the request kind.
// Timing: one byte is accepted per clock while s_tready is high. Each result
// is registered on the edge that accepts its byte. An output register backed
// by one skid entry decouples the sides: when the receiver stalls, one more
// result is held and s_tready falls only once the skid entry is occupied.
// Reset (rst, synchronous) empties the output, returns to header collection
// and restores the limit to its reset value.
module length_prefixed_frame_deframer_core (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: length limit.
  input  logic                               cfg_wr_en,
  input  logic [lpfd_pkg::FieldWidth-1:0]    cfg_wr_data,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lpfd_pkg::ByteWidth-1:0]     s_tdata,   // rx_byte
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // msg_id [15:0], msg_length [31:16], data_byte [39:32], byte_index [55:40]
  output logic [lpfd_pkg::TdataWidth-1:0]    m_tdata,
  output logic [lpfd_pkg::KindWidth-1:0]     m_tuser,   // item_kind
  output logic                               m_tlast    // last_byte
);

  logic [lpfd_pkg::FieldWidth-1:0] length_limit;
  logic                            in_accept;
  logic                            res_valid;
  lpfd_pkg::result_t               res;
  lpfd_pkg::result_t               out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= lpfd_pkg::MaxLengthReset;
    end else if (cfg_wr_en) begin
      length_limit <= cfg_wr_data;
    end
  end

  assign in_accept = s_tvalid && s_tready;

  lpfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (in_accept),
    .in_byte      (s_tdata),
    .length_limit (length_limit),
    .res_valid    (res_valid),
    .res          (res)
  );

  // The parser's result is captured in the same edge that accepts its byte.
  lpfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {out_data.byte_index, out_data.data_byte,
                    out_data.msg_length, out_data.msg_id};
  assign m_tuser = out_data.kind;
  assign m_tlast = out_data.last_byte;

endmodule

/* sv/lpfd_checker.sv */
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpfd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lpfd_pkg::TdataWidth-1:0] m_tdata,
  input logic [lpfd_pkg::KindWidth-1:0]  m_tuser,
  input logic                            m_tlast
);

  // A result that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Non-body requests always end a message.
  a_nonbody_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != lpfd_pkg::KIND_BODY) |-> m_tlast)
    else $error("non-body request without tlast");

  // Non-body requests carry a zero byte and a zero index.
  a_nonbody_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != lpfd_pkg::KIND_BODY) |-> (m_tdata[55:32] == 24'd0))
    else $error("non-body request with byte or index set");

  // Input is only refused while the output stage holds results.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |-> m_tvalid)
    else $error("input refused with an empty output stage");

endmodule

bind length_prefixed_frame_deframer_core lpfd_checker u_lpfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
